// File: hw/rtl/wmmu_pkg.sv
// Shared types, codes and saturation helper for the weight matrix update block.
`timescale 1ns / 1ps
package wmmu_pkg;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [23:0] value_a;
    logic signed [23:0] value_b;
    logic               clear_deltas;
  } req_t;

  typedef struct packed {
    logic signed [23:0] result_value;
    logic [5:0]         result_row;
    logic               last_flag;
  } res_t;

  localparam logic [2:0] REQ_WR_WEIGHT = 3'd0;
  localparam logic [2:0] REQ_SET_ERR   = 3'd1;
  localparam logic [2:0] REQ_ADD_ERR   = 3'd2;
  localparam logic [2:0] REQ_LOAD_PRE  = 3'd3;
  localparam logic [2:0] REQ_LEARN     = 3'd4;
  localparam logic [2:0] REQ_RD_WEIGHT = 3'd5;

  localparam logic [1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [1:0] REG_MOMENTUM   = 2'd1;
  localparam logic [1:0] REG_UPD_EN     = 2'd2;

  localparam logic [15:0] LEARN_RATE_RST = 16'd19661;
  localparam logic [15:0] MOMENTUM_RST   = 16'd0;

  localparam logic signed [49:0] SAT_MAX = 50'sd8388607;
  localparam logic signed [49:0] SAT_MIN = -50'sd8388608;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_ADD  = 7'b0001000,
    S_RD   = 7'b0010000,
    S_BP   = 7'b0100000,
    S_UPD  = 7'b1000000
  } state_t;

  function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
    logic signed [23:0] r;
    if (v > SAT_MAX) r = 24'sh7FFFFF;
    else if (v < SAT_MIN) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/weight_matrix_momentum_update_top.sv
// Top level: weight matrix with momentum learning, memory based read-modify-write.
`timescale 1ns / 1ps
// One item at a time; busy is high while an item is at work. A learn item walks the
// weight memory one weight per cycle through its single read port: once for the
// back-propagated errors (one result per row, last_flag on the final one), then, with
// update_enable set, a second time for the weight update. clear_deltas adds a sweep
// over the delta memory before the item runs. After reset the block clears weights
// and deltas with busy high. Results appear for one cycle on out_res with out_strobe;
// the receiver cannot stall them.
module weight_matrix_momentum_update_top import wmmu_pkg::*; #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  req_t        in_req,
  output logic        out_strobe,
  output res_t        out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N  = ROWS * COLS;
  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // configuration
  logic [15:0] learn_rate_r;
  logic [15:0] momentum_r;
  logic        upd_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r <= LEARN_RATE_RST;
      momentum_r   <= MOMENTUM_RST;
      upd_en_r     <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_LEARN_RATE: learn_rate_r <= pwdata[15:0];
        REG_MOMENTUM:   momentum_r   <= pwdata[15:0];
        REG_UPD_EN:     upd_en_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LEARN_RATE: prdata = {16'd0, learn_rate_r};
      REG_MOMENTUM:   prdata = {16'd0, momentum_r};
      REG_UPD_EN:     prdata = {31'd0, upd_en_r};
      default:        prdata = 32'd0;
    endcase
  end
  assign pready = 1'b1;

  // memories
  logic              w_we, d_we, e_we, p_we;
  logic [AW-1:0]     w_waddr, w_raddr, d_waddr;
  logic [CW-1:0]     e_waddr, e_raddr;
  logic [RW-1:0]     p_waddr, p_raddr;
  logic [23:0]       w_wdata, d_wdata, e_wdata, p_wdata;
  logic [23:0]       w_q, d_q, e_q, p_q;

  wmmu_ram #(.DEPTH(N), .AW(AW), .WIDTH(24)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_q));
  wmmu_ram #(.DEPTH(N), .AW(AW), .WIDTH(24)) u_delta (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(w_raddr), .rdata(d_q));
  wmmu_ram #(.DEPTH(COLS), .AW(CW), .WIDTH(24)) u_error (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_q));
  wmmu_ram #(.DEPTH(ROWS), .AW(RW), .WIDTH(24)) u_preout (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_q));

  // control
  state_t        state_r, state_nxt;
  req_t          req_r;
  logic          clr_all_r, clr_all_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [RW-1:0] r_r, r_nxt;
  logic          iss_done_r, iss_done_nxt;
  logic [COLS-1:0] err_vld_r, err_vld_nxt;
  logic          ev1_r;
  logic          out_strobe_nxt;
  res_t          out_res_nxt, out_res_r;
  logic          out_strobe_r;

  // pipeline tags
  logic          iss;
  logic          v1_r, v2_r, v3_r;
  logic [AW-1:0] a1_r, a2_r, a3_r;
  logic [RW-1:0] row1_r, row2_r;
  logic          first1_r, first2_r, lastc1_r, lastc2_r;

  // datapath
  logic signed [23:0] errv;
  logic signed [47:0] prod_r;
  logic signed [23:0] acc_r, term, acc_sum;
  logic signed [40:0] pt_r, pm_r;
  logic signed [23:0] wv1_r, pre1_r, wv2_r, m2_r, t_s2, g_s3, d_s3, wn_s3;
  logic signed [47:0] pg_r;

  logic          row_ok, col_ok;
  logic [AW-1:0] req_addr;
  logic          last_elem;

  assign row_ok   = {1'b0, req_r.row_index} < 7'(ROWS);
  assign col_ok   = {1'b0, req_r.col_index} < 7'(COLS);
  assign req_addr = AW'(int'(req_r.row_index) * COLS + int'(req_r.col_index));
  assign errv     = ev1_r ? $signed(e_q) : 24'sd0;
  assign last_elem = (addr_r == AW'(N - 1));

  assign term    = sat24(50'(prod_r >>> 16));
  assign acc_sum = sat24(50'(first2_r ? 24'sd0 : acc_r) + 50'(term));
  assign t_s2    = sat24(50'(pt_r >>> 16));
  assign g_s3    = sat24(50'(pg_r >>> 16));
  assign d_s3    = sat24(50'(g_s3) + 50'(m2_r));
  assign wn_s3   = sat24(50'(wv2_r) + 50'(d_s3));

  assign iss = !iss_done_r && (state_r == S_BP || state_r == S_UPD);

  always_comb begin
    state_nxt      = state_r;
    clr_all_nxt    = clr_all_r;
    addr_nxt       = addr_r;
    c_nxt          = c_r;
    r_nxt          = r_r;
    iss_done_nxt   = iss_done_r;
    err_vld_nxt    = err_vld_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    w_we = 1'b0; w_waddr = addr_r; w_wdata = 24'd0; w_raddr = addr_r;
    d_we = 1'b0; d_waddr = addr_r; d_wdata = 24'd0;
    e_we = 1'b0; e_waddr = CW'(req_r.col_index); e_wdata = 24'd0; e_raddr = c_r;
    p_we = 1'b0; p_waddr = RW'(req_r.row_index); p_wdata = req_r.value_a; p_raddr = r_r;

    if (iss) begin
      addr_nxt = addr_r + AW'(1);
      if (c_r == CW'(COLS - 1)) begin
        c_nxt = '0;
        r_nxt = r_r + RW'(1);
      end else begin
        c_nxt = c_r + CW'(1);
      end
      if (last_elem) iss_done_nxt = 1'b1;
    end

    unique case (state_r)
      S_CLR: begin
        w_we = clr_all_r;
        d_we = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (last_elem) state_nxt = clr_all_r ? S_IDLE : S_EXEC;
      end
      S_IDLE: begin
        if (start) begin
          addr_nxt    = '0;
          clr_all_nxt = 1'b0;
          state_nxt   = in_req.clear_deltas ? S_CLR : S_EXEC;
        end
      end
      S_EXEC: begin
        addr_nxt = '0;
        c_nxt = '0;
        r_nxt = '0;
        iss_done_nxt = 1'b0;
        e_raddr = CW'(req_r.col_index);
        w_raddr = req_addr;
        state_nxt = S_IDLE;
        unique case (req_r.req_type)
          REQ_WR_WEIGHT: begin
            w_we = row_ok && col_ok;
            w_waddr = req_addr;
            w_wdata = req_r.value_a;
          end
          REQ_SET_ERR: begin
            if (col_ok) begin
              e_we = 1'b1;
              e_wdata = sat24(50'(req_r.value_a) - 50'(req_r.value_b));
              err_vld_nxt[CW'(req_r.col_index)] = 1'b1;
            end
          end
          REQ_ADD_ERR:   if (col_ok) state_nxt = S_ADD;
          REQ_LOAD_PRE:  p_we = row_ok;
          REQ_LEARN:     state_nxt = S_BP;
          REQ_RD_WEIGHT: state_nxt = S_RD;
          default: ;
        endcase
      end
      S_ADD: begin
        e_we = 1'b1;
        e_wdata = sat24(50'(errv) + 50'(req_r.value_a));
        err_vld_nxt[CW'(req_r.col_index)] = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD: begin
        out_strobe_nxt = 1'b1;
        out_res_nxt.result_value = (row_ok && col_ok) ? $signed(w_q) : 24'sd0;
        out_res_nxt.result_row   = req_r.row_index;
        out_res_nxt.last_flag    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_BP: begin
        if (v2_r && lastc2_r) begin
          out_strobe_nxt = 1'b1;
          out_res_nxt.result_value = acc_sum;
          out_res_nxt.result_row   = 6'(row2_r);
          out_res_nxt.last_flag    = (row2_r == RW'(ROWS - 1));
          if (row2_r == RW'(ROWS - 1)) begin
            addr_nxt = '0;
            c_nxt = '0;
            r_nxt = '0;
            iss_done_nxt = 1'b0;
            if (upd_en_r) begin
              state_nxt = S_UPD;
            end else begin
              err_vld_nxt = '0;
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_UPD: begin
        if (v3_r) begin
          w_we = 1'b1; w_waddr = a3_r; w_wdata = wn_s3;
          d_we = 1'b1; d_waddr = a3_r; d_wdata = d_s3;
          if (a3_r == AW'(N - 1)) begin
            err_vld_nxt = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_all_r    <= 1'b1;
      addr_r       <= '0;
      c_r          <= '0;
      r_r          <= '0;
      iss_done_r   <= 1'b1;
      err_vld_r    <= '0;
      out_strobe_r <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_all_r    <= clr_all_nxt;
      addr_r       <= addr_nxt;
      c_r          <= c_nxt;
      r_r          <= r_nxt;
      iss_done_r   <= iss_done_nxt;
      err_vld_r    <= err_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      v1_r         <= iss;
      v2_r         <= v1_r;
      v3_r         <= v2_r && (state_r == S_UPD);
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) req_r <= in_req;
    out_res_r <= out_res_nxt;
    ev1_r     <= err_vld_r[e_raddr];
    a1_r      <= addr_r;
    a2_r      <= a1_r;
    a3_r      <= a2_r;
    row1_r    <= r_r;
    row2_r    <= row1_r;
    first1_r  <= (c_r == '0);
    first2_r  <= first1_r;
    lastc1_r  <= (c_r == CW'(COLS - 1));
    lastc2_r  <= lastc1_r;
    if (v2_r) acc_r <= acc_sum;
    prod_r    <= $signed(w_q) * errv;
    pt_r      <= $signed({1'b0, learn_rate_r}) * errv;
    pm_r      <= $signed({1'b0, momentum_r}) * $signed(d_q);
    wv1_r     <= $signed(w_q);
    pre1_r    <= $signed(p_q);
    pg_r      <= t_s2 * pre1_r;
    m2_r      <= sat24(50'(pm_r >>> 16));
    wv2_r     <= wv1_r;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

// File: hw/rtl/wmmu_ram.sv
// Simple dual-port synchronous RAM, one write port and one registered read port.
`timescale 1ns / 1ps
module wmmu_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int WIDTH = 24
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
